FILE: hdl/dbcpd_pkg.sv
// Package for the double-byte code page decoder: item types, function and
// status codes, and the table access structures shared by the top level and
// the table block. It depends on nothing else.
package dbcpd_pkg;

  localparam int MAX_LEAD_ROWS_DEF = 128;
  localparam int BYTE_W            = 8;
  localparam int ROW_W             = 7;
  localparam int UNIT_W            = 16;
  localparam int BYTE_ENTRIES      = 256;

  localparam logic [UNIT_W-1:0] INVALID_UNIT = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD_LEAD   = 2'd0,
    FUNC_LOAD_SINGLE = 2'd1,
    FUNC_LOAD_PAIR   = 2'd2,
    FUNC_DECODE      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [BYTE_W-1:0]  byte_value;
    logic [BYTE_W-1:0]  trail_value;
    logic [ROW_W-1:0]   row_index;
    logic               is_lead;
    logic [UNIT_W-1:0]  code_unit_in;
    logic               message_end;
  } in_item_t;

  typedef struct packed {
    logic [UNIT_W-1:0]  code_unit;
    status_t            status;
    logic               last_of_message;
  } out_item_t;

  // Write and read request to the table block.
  typedef struct packed {
    logic               wr_lead;
    logic               wr_single;
    logic               wr_pair;
    logic               rd;
    logic [BYTE_W-1:0]  byte_value;
    logic [BYTE_W-1:0]  trail_value;
    logic [ROW_W-1:0]   row_index;
    logic               is_lead;
    logic [UNIT_W-1:0]  unit;
    logic [ROW_W-1:0]   pair_row;
  } tbl_req_t;

  // Registered read data from the table block.
  typedef struct packed {
    logic               lead_flag;
    logic [ROW_W-1:0]   lead_row;
    logic [UNIT_W-1:0]  single_unit;
    logic [UNIT_W-1:0]  pair_unit;
  } tbl_rd_t;

endpackage

FILE: hdl/double_byte_code_page_decoder.sv
// Top level of the double-byte code page decoder: input stage, decode state
// and result register around the table block.
// Depends on dbcpd_pkg and dbcpd_tables.
//
// This block turns a byte stream in a single- or double-byte code page into
// 16-bit code units. Load transfers (lead entry, single map, pair entry) fill
// the tables; they give no result. Decode transfers carry one byte each: a
// lead byte is held and gives no result, the byte after it is taken as its
// trail and looked up in the lead's pair row, and any other byte goes through
// the single-byte map. A code unit of 0xFFFF yields an invalid-sequence
// result and the rest of the message, up to the byte flagged as message end,
// is dropped; a lead byte flagged as message end yields a truncated result.
// The block takes one transfer in every clock cycle while its output is not
// stalled, and each result passes through the registered table read and then
// the result register. Every table read happens in the accept cycle, and
// the pair row for a trail byte is forwarded from the previous byte's
// lookup, which is what lets a trail follow its lead directly. The lead
// flags clear at reset; the other tables hold nothing meaningful until they
// are loaded, and no clearing pass runs.
module double_byte_code_page_decoder #(
  parameter int MAX_LEAD_ROWS = dbcpd_pkg::MAX_LEAD_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  dbcpd_pkg::in_item_t  byte_item,
  output logic                 unit_valid,
  input  logic                 unit_stall,
  output dbcpd_pkg::out_item_t unit_item
);
  import dbcpd_pkg::*;

  // Row numbers are at most 127, so eight bits hold a limit of up to 128.
  localparam logic [ROW_W:0] ROW_LIM = (ROW_W + 1)'(MAX_LEAD_ROWS);

  logic      accept;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_go;

  // Decode state.
  logic [BYTE_W-1:0] held_lead, held_lead_next;
  logic [ROW_W-1:0]  held_row, held_row_next;
  logic              lead_pending, lead_pending_next;
  logic              discarding, discarding_next;

  logic              res_valid;
  out_item_t         res_item;
  logic              have_unit;
  logic [UNIT_W-1:0] unit_sel;

  tbl_req_t req;
  tbl_rd_t  rd;

  // The input stage moves on when the result register is empty or its
  // transfer completes in this cycle.
  assign s1_go      = s1_valid && (!unit_valid || !unit_stall);
  assign byte_stall = s1_valid && !s1_go;
  assign accept     = byte_valid && !byte_stall;

  // Table requests are issued as the transfer is taken, so loads and lookups
  // reach the tables in stream order. The pair row is the one that the held
  // lead will have once the item now in the input stage has been processed.
  always_comb begin
    req.wr_lead     = accept && (byte_item.func == FUNC_LOAD_LEAD) &&
                      ({1'b0, byte_item.row_index} < ROW_LIM);
    req.wr_single   = accept && (byte_item.func == FUNC_LOAD_SINGLE);
    req.wr_pair     = accept && (byte_item.func == FUNC_LOAD_PAIR) &&
                      ({1'b0, byte_item.row_index} < ROW_LIM);
    req.rd          = accept && (byte_item.func == FUNC_DECODE);
    req.byte_value  = byte_item.byte_value;
    req.trail_value = byte_item.trail_value;
    req.row_index   = byte_item.row_index;
    req.is_lead     = byte_item.is_lead;
    req.unit        = byte_item.code_unit_in;
    req.pair_row    = held_row_next;
  end

  dbcpd_tables #(
    .MAX_LEAD_ROWS(MAX_LEAD_ROWS)
  ) u_tables (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rd (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= byte_item;
    end
  end

  // Decode step for the item in the input stage, using the table data read
  // when it was taken.
  always_comb begin
    held_lead_next    = held_lead;
    held_row_next     = held_row;
    lead_pending_next = lead_pending;
    discarding_next   = discarding;
    res_valid         = 1'b0;
    res_item          = '0;
    have_unit         = 1'b0;
    unit_sel          = '0;

    if (s1_go) begin
      case (s1_item.func)
        FUNC_LOAD_LEAD: begin
          // A reload of the held lead's row moves a pending trail lookup
          // to the new row.
          if (({1'b0, s1_item.row_index} < ROW_LIM) &&
              (s1_item.byte_value == held_lead)) begin
            held_row_next = s1_item.row_index;
          end
        end
        FUNC_DECODE: begin
          if (discarding) begin
            if (s1_item.message_end) begin
              discarding_next = 1'b0;
            end
          end else if (lead_pending) begin
            lead_pending_next = 1'b0;
            have_unit         = 1'b1;
            unit_sel          = ({1'b0, held_row} < ROW_LIM) ? rd.pair_unit : INVALID_UNIT;
          end else if (rd.lead_flag) begin
            if (s1_item.message_end) begin
              res_valid                = 1'b1;
              res_item.code_unit       = '0;
              res_item.status          = ST_TRUNCATED;
              res_item.last_of_message = 1'b1;
            end else begin
              held_lead_next    = s1_item.byte_value;
              held_row_next     = rd.lead_row;
              lead_pending_next = 1'b1;
            end
          end else begin
            have_unit = 1'b1;
            unit_sel  = rd.single_unit;
          end
        end
        default: begin
        end
      endcase
    end

    if (have_unit) begin
      res_valid = 1'b1;
      if (unit_sel == INVALID_UNIT) begin
        res_item.code_unit       = '0;
        res_item.status          = ST_INVALID;
        res_item.last_of_message = 1'b1;
        if (!s1_item.message_end) begin
          discarding_next = 1'b1;
        end
      end else begin
        res_item.code_unit       = unit_sel;
        res_item.status          = ST_OK;
        res_item.last_of_message = s1_item.message_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead    <= '0;
      held_row     <= '0;
      lead_pending <= 1'b0;
      discarding   <= 1'b0;
    end else begin
      held_lead    <= held_lead_next;
      held_row     <= held_row_next;
      lead_pending <= lead_pending_next;
      discarding   <= discarding_next;
    end
  end

  // Result register: loaded whenever it is empty or its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (!unit_valid || !unit_stall) begin
      unit_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      unit_item <= res_item;
    end
  end

endmodule

FILE: hdl/dbcpd_tables.sv
// Lookup tables of the decoder: lead flags, lead rows, single-byte map and
// pair map, each with one write and one registered read per cycle.
// Depends on dbcpd_pkg.
module dbcpd_tables #(
  parameter int MAX_LEAD_ROWS = dbcpd_pkg::MAX_LEAD_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dbcpd_pkg::tbl_req_t req,
  output dbcpd_pkg::tbl_rd_t  rd
);
  import dbcpd_pkg::*;

  localparam int PAIR_DEPTH = MAX_LEAD_ROWS * BYTE_ENTRIES;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

  logic [BYTE_ENTRIES-1:0] lead_flags;
  logic [ROW_W-1:0]        lead_rows  [BYTE_ENTRIES];
  logic [UNIT_W-1:0]       single_map [BYTE_ENTRIES];
  logic [UNIT_W-1:0]       pair_map   [PAIR_DEPTH];

  logic [PAIR_AW-1:0] pair_waddr;
  logic [PAIR_AW-1:0] pair_raddr;

  // Row numbers are below MAX_LEAD_ROWS, so the row and byte concatenation
  // always lands inside the pair map.
  assign pair_waddr = PAIR_AW'({req.row_index, req.trail_value});
  assign pair_raddr = PAIR_AW'({req.pair_row, req.byte_value});

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_flags <= '0;
    end else if (req.wr_lead) begin
      lead_flags[req.byte_value] <= req.is_lead;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_lead) begin
      lead_rows[req.byte_value] <= req.row_index;
    end
    if (req.wr_single) begin
      single_map[req.byte_value] <= req.unit;
    end
    if (req.wr_pair) begin
      pair_map[pair_waddr] <= req.unit;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd.lead_flag   <= lead_flags[req.byte_value];
      rd.lead_row    <= lead_rows[req.byte_value];
      rd.single_unit <= single_map[req.byte_value];
      rd.pair_unit   <= pair_map[pair_raddr];
    end
  end

endmodule

FILE: bench/dbcpd_checker.sv
// Scoreboard for the double-byte code page decoder: watches both channels,
// predicts the code units that each accepted byte transfer should yield and
// compares them. Depends on dbcpd_pkg.
`timescale 1ns / 1ps

module dbcpd_checker #(
  parameter int MAX_LEAD_ROWS = dbcpd_pkg::MAX_LEAD_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  logic                 byte_stall,
  input  dbcpd_pkg::in_item_t  byte_item,
  input  logic                 unit_valid,
  input  logic                 unit_stall,
  input  dbcpd_pkg::out_item_t unit_item,
  output int                   mismatches,
  output int                   units_pending,
  output int                   units_checked
);
  import dbcpd_pkg::*;

  // Private copy of the tables and of the decode state.
  logic              lead_flag   [BYTE_ENTRIES];
  logic [ROW_W-1:0]  lead_row    [BYTE_ENTRIES];
  logic [UNIT_W-1:0] single_unit [BYTE_ENTRIES];
  logic [UNIT_W-1:0] pair_unit   [MAX_LEAD_ROWS*BYTE_ENTRIES];
  logic [BYTE_W-1:0] held_byte;
  logic              trail_due;
  logic              dropping;

  out_item_t expected_units [$];
  int        fails;
  int        checked;

  // Applies one accepted transfer; returns 1 when it yields a code unit.
  function automatic bit decode_transfer(input in_item_t it, output out_item_t res);
    logic [UNIT_W-1:0] cu;
    res = '0;
    case (it.func)
      FUNC_LOAD_LEAD: begin
        if (int'(it.row_index) < MAX_LEAD_ROWS) begin
          lead_flag[it.byte_value] = it.is_lead;
          lead_row[it.byte_value]  = it.row_index;
        end
        return 1'b0;
      end
      FUNC_LOAD_SINGLE: begin
        single_unit[it.byte_value] = it.code_unit_in;
        return 1'b0;
      end
      FUNC_LOAD_PAIR: begin
        if (int'(it.row_index) < MAX_LEAD_ROWS)
          pair_unit[int'(it.row_index)*BYTE_ENTRIES + int'(it.trail_value)] = it.code_unit_in;
        return 1'b0;
      end
      default: ;
    endcase

    if (dropping) begin
      if (it.message_end) dropping = 1'b0;
      return 1'b0;
    end

    if (trail_due) begin
      trail_due = 1'b0;
      cu = (int'(lead_row[held_byte]) < MAX_LEAD_ROWS) ?
           pair_unit[int'(lead_row[held_byte])*BYTE_ENTRIES + int'(it.byte_value)] :
           INVALID_UNIT;
    end else if (lead_flag[it.byte_value]) begin
      if (it.message_end) begin
        res.status          = ST_TRUNCATED;
        res.last_of_message = 1'b1;
        return 1'b1;
      end
      held_byte = it.byte_value;
      trail_due = 1'b1;
      return 1'b0;
    end else begin
      cu = single_unit[it.byte_value];
    end

    if (cu == INVALID_UNIT) begin
      if (!it.message_end) dropping = 1'b1;
      res.status          = ST_INVALID;
      res.last_of_message = 1'b1;
      return 1'b1;
    end
    res.code_unit       = cu;
    res.status          = ST_OK;
    res.last_of_message = it.message_end;
    return 1'b1;
  endfunction

  initial begin
    fails   = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t res;
    if (rst) begin
      for (int i = 0; i < BYTE_ENTRIES; i++) lead_flag[i] = 1'b0;
      held_byte = '0;
      trail_due = 1'b0;
      dropping  = 1'b0;
      expected_units.delete();
    end else begin
      // Results are checked before the new byte is predicted; as each result passes
      // the table read and result registers, a byte never yields it on its own edge.
      if (unit_valid && !unit_stall) begin
        if (expected_units.size() == 0) begin
          $error("unexpected code unit transfer: %h status %0d last %b",
                 unit_item.code_unit, unit_item.status, unit_item.last_of_message);
          fails++;
        end else begin
          want = expected_units.pop_front();
          checked++;
          if (unit_item.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, unit_item.code_unit);
            fails++;
          end
          if (unit_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, unit_item.status);
            fails++;
          end
          if (unit_item.last_of_message !== want.last_of_message) begin
            $error("last_of_message: expected %b, got %b",
                   want.last_of_message, unit_item.last_of_message);
            fails++;
          end
        end
      end
      if (byte_valid && !byte_stall) begin
        if (decode_transfer(byte_item, res))
          expected_units.insert(expected_units.size(), res);
      end
    end
    mismatches    <= fails;
    units_pending <= expected_units.size();
    units_checked <= checked;
  end

endmodule

FILE: bench/tb_top.sv
// Top of the decoder testbench: clock, reset, stimulus and verdict.
// Depends on dbcpd_pkg, double_byte_code_page_decoder and dbcpd_checker.
`timescale 1ns / 1ps

module tb_top;
  import dbcpd_pkg::*;

  logic      clk;
  logic      rst        = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item  = '0;
  logic      unit_valid;
  logic      unit_stall = 1'b0;
  out_item_t unit_item;

  int mismatches;
  int units_pending;
  int units_checked;

  // Idling percentages for the sending and receiving sides.
  int idle_pct  = 0;
  int stall_pct = 0;

  int transfers_sent = 0;
  int loads_sent     = 0;
  int bytes_sent     = 0;

  // What the stimulus knows of the tables, so that it never makes the block
  // read an entry that has not been written. A lead load always writes its
  // row, so the lead rows need no written mark of their own.
  bit         lead_set    [256];
  logic [6:0] lead_row_of [256];
  bit         single_set  [256];
  bit         single_bad  [256];
  bit         pair_set    [32768];
  bit         pair_bad    [32768];
  bit         trail_next  = 1'b0;
  bit         skipping    = 1'b0;
  logic [7:0] held_lead   = '0;

  double_byte_code_page_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_item  (unit_item)
  );

  dbcpd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_item     (byte_item),
    .unit_valid    (unit_valid),
    .unit_stall    (unit_stall),
    .unit_item     (unit_item),
    .mismatches    (mismatches),
    .units_pending (units_pending),
    .units_checked (units_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiving side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    unit_stall <= ($urandom_range(99) < stall_pct);
  end

  // Fields that the function does not use are filled with noise, which also
  // helps every input bit to take both values.
  function automatic in_item_t noise_item(input func_t f);
    in_item_t it;
    it.func         = f;
    it.byte_value   = 8'($urandom);
    it.trail_value  = 8'($urandom);
    it.row_index    = 7'($urandom);
    it.is_lead      = 1'($urandom);
    it.code_unit_in = 16'($urandom);
    it.message_end  = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t lead_load(input logic [7:0] b, input bit flag,
                                         input logic [6:0] row);
    in_item_t it;
    it            = noise_item(FUNC_LOAD_LEAD);
    it.byte_value = b;
    it.is_lead    = flag;
    it.row_index  = row;
    return it;
  endfunction

  function automatic in_item_t single_load(input logic [7:0] b, input logic [15:0] cu);
    in_item_t it;
    it              = noise_item(FUNC_LOAD_SINGLE);
    it.byte_value   = b;
    it.code_unit_in = cu;
    return it;
  endfunction

  function automatic in_item_t pair_load(input logic [6:0] row, input logic [7:0] t,
                                         input logic [15:0] cu);
    in_item_t it;
    it              = noise_item(FUNC_LOAD_PAIR);
    it.row_index    = row;
    it.trail_value  = t;
    it.code_unit_in = cu;
    return it;
  endfunction

  function automatic in_item_t code_byte(input logic [7:0] b, input bit last);
    in_item_t it;
    it             = noise_item(FUNC_DECODE);
    it.byte_value  = b;
    it.message_end = last;
    return it;
  endfunction

  // Roughly one table entry in eight is marked invalid.
  function automatic logic [15:0] random_unit();
    return ($urandom_range(7) == 0) ? INVALID_UNIT : 16'($urandom);
  endfunction

  // Keeps the stimulus' view of the tables and of the message state in step
  // with each accepted transfer.
  function automatic void follow_stream(input in_item_t it);
    int idx;
    idx = int'(it.row_index)*256 + int'(it.trail_value);
    transfers_sent++;
    case (it.func)
      FUNC_LOAD_LEAD: begin
        lead_set[it.byte_value]    = it.is_lead;
        lead_row_of[it.byte_value] = it.row_index;
        loads_sent++;
      end
      FUNC_LOAD_SINGLE: begin
        single_set[it.byte_value] = 1'b1;
        single_bad[it.byte_value] = (it.code_unit_in == INVALID_UNIT);
        loads_sent++;
      end
      FUNC_LOAD_PAIR: begin
        pair_set[idx] = 1'b1;
        pair_bad[idx] = (it.code_unit_in == INVALID_UNIT);
        loads_sent++;
      end
      default: begin
        bytes_sent++;
        if (skipping) begin
          skipping = !it.message_end;
        end else if (trail_next) begin
          trail_next = 1'b0;
          skipping   = !it.message_end &&
                       pair_bad[int'(lead_row_of[held_lead])*256 + int'(it.byte_value)];
        end else if (lead_set[it.byte_value]) begin
          trail_next = !it.message_end;
          held_lead  = it.byte_value;
        end else begin
          skipping = !it.message_end && single_bad[it.byte_value];
        end
      end
    endcase
  endfunction

  // Offers one transfer and returns on the rising edge that accepts it. The
  // stall is looked at on the falling edge, where it is settled and equal to
  // the value that the next rising edge will see, so nothing hangs on the
  // order of events within a time step.
  task automatic offer_transfer(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    forever begin
      @(negedge clk);
      if (!byte_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    follow_stream(it);
  endtask

  // Sends one byte of a message. A trail byte is chosen among the written
  // entries of the held lead's current row; where the row is still empty, or
  // a plain byte has no single-map entry, the missing entry is loaded first,
  // so loads also land between a lead and its trail.
  task automatic send_code_byte(input bit last);
    logic [7:0] b;
    int         row;
    int         slot;
    b = 8'($urandom);
    if (trail_next) begin
      row  = int'(lead_row_of[held_lead]);
      slot = -1;
      for (int k = 0; k < 256 && slot < 0; k++)
        if (pair_set[row*256 + (int'(b) + k) % 256]) slot = (int'(b) + k) % 256;
      if (slot < 0) offer_transfer(pair_load(7'(row), b, random_unit()));
      else b = 8'(slot);
    end else if (!lead_set[b] && !single_set[b]) begin
      offer_transfer(single_load(b, random_unit()));
    end
    offer_transfer(code_byte(b, last));
  endtask

  // A random table load. About half of the pair loads take their row from a byte's lead entry.
  function automatic in_item_t random_load();
    logic [6:0] row;
    case ($urandom_range(2))
      0:       return lead_load(8'($urandom), ($urandom_range(2) == 0), 7'($urandom));
      1:       return single_load(8'($urandom), random_unit());
      default: begin
        row = ($urandom_range(1) == 0) ? lead_row_of[8'($urandom)] : 7'($urandom);
        if ($isunknown(row)) row = 7'($urandom);
        return pair_load(row, 8'($urandom), random_unit());
      end
    endcase
  endfunction

  // Mostly well-formed messages of one to eight bytes that end on their last
  // byte; now and then a message is cut short by an early end flag, and a
  // load may fall anywhere inside a message.
  task automatic random_message();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) offer_transfer(random_load());
      send_code_byte((i == len - 1) || ($urandom_range(15) == 0));
    end
  endtask

  // Guard against a hung handshake; the slowest correct run needs well under
  // a tenth of this.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Rows 0 and 127 are used, the code units 0x0000, 0xFFFE
    // and the invalid 0xFFFF all appear, and a byte whose lead flag is left
    // clear is taken as a plain value.
    offer_transfer(lead_load(8'h81, 1'b1, 7'd127));
    offer_transfer(lead_load(8'hFE, 1'b1, 7'd0));
    offer_transfer(lead_load(8'h80, 1'b0, 7'd85));
    offer_transfer(single_load(8'h00, 16'h0000));
    offer_transfer(single_load(8'hFF, INVALID_UNIT));
    offer_transfer(single_load(8'h80, 16'hFFFE));
    offer_transfer(single_load(8'h41, 16'h0041));
    offer_transfer(pair_load(7'd127, 8'h00, 16'h1234));
    offer_transfer(pair_load(7'd127, 8'hFE, 16'hFFFE));
    offer_transfer(pair_load(7'd0, 8'h41, INVALID_UNIT));
    offer_transfer(pair_load(7'd0, 8'h00, 16'hABCD));
    // A plain byte, then a lead and trail pair closing the message.
    offer_transfer(code_byte(8'h00, 1'b0));
    offer_transfer(code_byte(8'h81, 1'b0));
    offer_transfer(code_byte(8'h00, 1'b1));
    // A lead on the last byte of a message is a truncation.
    offer_transfer(code_byte(8'h81, 1'b1));
    // The byte after a lead is its trail even when it is itself a lead.
    offer_transfer(code_byte(8'h81, 1'b0));
    offer_transfer(code_byte(8'hFE, 1'b0));
    // An invalid pair mid-message: the rest of the message is dropped.
    offer_transfer(code_byte(8'hFE, 1'b0));
    offer_transfer(code_byte(8'h41, 1'b0));
    offer_transfer(code_byte(8'h81, 1'b0));
    offer_transfer(code_byte(8'hFF, 1'b1));
    // The lead's row is changed while it is held; the trail uses the new row.
    offer_transfer(code_byte(8'h81, 1'b0));
    offer_transfer(lead_load(8'h81, 1'b1, 7'd0));
    offer_transfer(code_byte(8'h00, 1'b0));
    // An invalid plain byte on the message end, then an ordinary one.
    offer_transfer(code_byte(8'hFF, 1'b1));
    offer_transfer(code_byte(8'h80, 1'b1));

    // Random part in three idling profiles: the sender idles lightly while
    // the receiver stalls heavily, then the other way round, then neither.
    idle_pct  = 20;
    stall_pct = 70;
    while (transfers_sent < 490) random_message();
    idle_pct  = 70;
    stall_pct = 20;
    while (transfers_sent < 950) random_message();
    idle_pct  = 0;
    stall_pct = 0;
    while (transfers_sent < 1420) random_message();
    byte_valid <= 1'b0;

    // Drain: wait for every predicted code unit, then go on clocking so
    // that a stray extra result would still be seen.
    @(posedge clk);
    while (units_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d transfers: %0d table loads and %0d code bytes.",
             transfers_sent, loads_sent, bytes_sent);
    $display("%0d code units compared under three idling profiles.", units_checked);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
